/* rtl/rot3d_pkg.sv */
package rot3d_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int ANGLE_W    = 32;
  localparam int ANG_RED_W  = 25;
  localparam int T_W        = 23;
  localparam int RED_STEPS  = 8;
  localparam int CORDIC_W   = 32;

  localparam logic [31:0] DEG90_Q16     = 32'd5898240;
  localparam logic [31:0] DEG180_Q16    = 32'd11796480;
  localparam logic [31:0] DEG270_Q16    = 32'd17694720;
  localparam logic [31:0] DEG360_Q16    = 32'd23592960;
  // 2^31 mod 360 degrees, undoes the offset that makes the angle unsigned
  localparam logic [31:0] ANG_WRAP_OFFS = 32'd524288;
  localparam logic [26:0] DEG2RAD_Q32   = 27'd74961321;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_X    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_Z    = 2'd3
  } rot3d_axis_e;

  typedef struct packed {
    rot3d_axis_e axis;
    logic        neg_s;
    logic        neg_c;
  } rot3d_ctl_t;

  function automatic logic signed [CORDIC_W-1:0] atan_q30(input int unsigned idx);
    case (idx)
      0:  atan_q30 = 32'sd843314857;
      1:  atan_q30 = 32'sd497837829;
      2:  atan_q30 = 32'sd263043837;
      3:  atan_q30 = 32'sd133525159;
      4:  atan_q30 = 32'sd67021687;
      5:  atan_q30 = 32'sd33543516;
      6:  atan_q30 = 32'sd16775851;
      7:  atan_q30 = 32'sd8388437;
      8:  atan_q30 = 32'sd4194283;
      9:  atan_q30 = 32'sd2097149;
      10: atan_q30 = 32'sd1048576;
      11: atan_q30 = 32'sd524288;
      12: atan_q30 = 32'sd262144;
      13: atan_q30 = 32'sd131072;
      14: atan_q30 = 32'sd65536;
      15: atan_q30 = 32'sd32768;
      16: atan_q30 = 32'sd16384;
      17: atan_q30 = 32'sd8192;
      18: atan_q30 = 32'sd4096;
      19: atan_q30 = 32'sd2048;
      20: atan_q30 = 32'sd1024;
      21: atan_q30 = 32'sd512;
      22: atan_q30 = 32'sd256;
      23: atan_q30 = 32'sd128;
      24: atan_q30 = 32'sd64;
      25: atan_q30 = 32'sd32;
      26: atan_q30 = 32'sd16;
      27: atan_q30 = 32'sd8;
      28: atan_q30 = 32'sd4;
      29: atan_q30 = 32'sd2;
      30: atan_q30 = 32'sd1;
      default: atan_q30 = 32'sd0;
    endcase
  endfunction

endpackage

/* rtl/rot3d_mod_cell.sv */
module rot3d_mod_cell #(
  parameter int SIDE_W = 1,
  parameter int SHIFT  = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [31:0]             in_rem_i,
  input  rot3d_pkg::rot3d_ctl_t   in_ctl_i,
  input  logic [SIDE_W-1:0]       in_side_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [31:0]             out_rem_o,
  output rot3d_pkg::rot3d_ctl_t   out_ctl_o,
  output logic [SIDE_W-1:0]       out_side_o
);
  import rot3d_pkg::*;

  localparam logic [32:0] STEP = {1'b0, DEG360_Q16} << SHIFT;

  logic              valid_q;
  logic [31:0]       rem_d, rem_q;
  rot3d_ctl_t        ctl_q;
  logic [SIDE_W-1:0] side_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    if ({1'b0, in_rem_i} >= STEP) begin
      rem_d = in_rem_i - STEP[31:0];
    end else begin
      rem_d = in_rem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rem_q  <= rem_d;
      ctl_q  <= in_ctl_i;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rem_o   = rem_q;
  assign out_ctl_o   = ctl_q;
  assign out_side_o  = side_q;

endmodule

/* rtl/rot3d_cordic_cell.sv */
module rot3d_cordic_cell #(
  parameter int SIDE_W = 1,
  parameter int STAGE  = 0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic signed [rot3d_pkg::CORDIC_W-1:0]     in_x_i,
  input  logic signed [rot3d_pkg::CORDIC_W-1:0]     in_y_i,
  input  logic signed [rot3d_pkg::CORDIC_W-1:0]     in_z_i,
  input  rot3d_pkg::rot3d_ctl_t                     in_ctl_i,
  input  logic [SIDE_W-1:0]                         in_side_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic signed [rot3d_pkg::CORDIC_W-1:0]     out_x_o,
  output logic signed [rot3d_pkg::CORDIC_W-1:0]     out_y_o,
  output logic signed [rot3d_pkg::CORDIC_W-1:0]     out_z_o,
  output rot3d_pkg::rot3d_ctl_t                     out_ctl_o,
  output logic [SIDE_W-1:0]                         out_side_o
);
  import rot3d_pkg::*;

  localparam logic signed [CORDIC_W-1:0] ATAN = atan_q30(STAGE);

  logic                       valid_q;
  logic signed [CORDIC_W-1:0] dx, dy;
  logic signed [CORDIC_W-1:0] x_d, y_d, z_d;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  rot3d_ctl_t                 ctl_q;
  logic [SIDE_W-1:0]          side_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    dx = in_y_i >>> STAGE;
    dy = in_x_i >>> STAGE;
    if (!in_z_i[CORDIC_W-1]) begin
      x_d = in_x_i - dx;
      y_d = in_y_i + dy;
      z_d = in_z_i - ATAN;
    end else begin
      x_d = in_x_i + dx;
      y_d = in_y_i - dy;
      z_d = in_z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      ctl_q  <= in_ctl_i;
      side_q <= in_side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_x_o     = x_q;
  assign out_y_o     = y_q;
  assign out_z_o     = z_q;
  assign out_ctl_o   = ctl_q;
  assign out_side_o  = side_q;

endmodule

/* rtl/rot3d_mac.sv */
module rot3d_mac #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic signed [rot3d_pkg::CORDIC_W-1:0]     in_cos_i,
  input  logic signed [rot3d_pkg::CORDIC_W-1:0]     in_sin_i,
  input  rot3d_pkg::rot3d_ctl_t                     in_ctl_i,
  input  logic [3*COORD_WIDTH-1:0]                  in_side_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [COORD_WIDTH-1:0]                    out_x_o,
  output logic [COORD_WIDTH-1:0]                    out_y_o,
  output logic [COORD_WIDTH-1:0]                    out_z_o,
  output logic                                      out_bad_o
);
  import rot3d_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int CW    = CORDIC_W;
  localparam int PH_W  = W - 15;
  localparam int HP_W  = PH_W + CW;
  localparam int LP_W  = 17 + CW;
  localparam int HS_W  = HP_W + 1;
  localparam int LS_W  = LP_W + 1;
  localparam int TOT_W = W + 35;
  localparam int Q_W   = TOT_W - 30;
  localparam logic signed [TOT_W-1:0] RND = TOT_W'(1) <<< 29;
  localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] round_sat(input logic signed [TOT_W-1:0] t);
    logic [Q_W-1:0] q;
    q = t[TOT_W-1:30];
    if ((q[Q_W-1:W-1] == '0) || (q[Q_W-1:W-1] == '1)) begin
      round_sat = q[W-1:0];
    end else if (q[Q_W-1]) begin
      round_sat = C_MIN;
    end else begin
      round_sat = C_MAX;
    end
  endfunction

  logic v0_q, v1_q, v2_q, v3_q;
  logic r0, r1, r2, r3;

  assign r3 = !v3_q || out_ready_i;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign r0 = !v0_q || r1;
  assign in_ready_o = r0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r0) v0_q <= in_valid_i;
      if (r1) v1_q <= v0_q;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // operand select: first = u*c + v*sp, second = u*sn + v*c
  logic [W-1:0]            in_x, in_y, in_z, u, v;
  logic signed [W:0]       ue, ve;
  logic signed [CW-1:0]    c_d, sp_d, sn_d, sin_neg;
  logic                    s_flip;

  logic [3*W-1:0]          side0_q, side1_q, side2_q;
  rot3d_axis_e             axis0_q, axis1_q, axis2_q;
  logic signed [PH_W-1:0]  uh_q, vh_q;
  logic [15:0]             ul_q, vl_q;
  logic signed [CW-1:0]    c_q, sp_q, sn_q;

  assign in_x = in_side_i[W-1:0];
  assign in_y = in_side_i[2*W-1:W];
  assign in_z = in_side_i[3*W-1:2*W];

  always_comb begin
    case (in_ctl_i.axis)
      AXIS_X: begin
        u = in_y;
        v = in_z;
      end
      AXIS_Y: begin
        u = in_x;
        v = in_z;
      end
      default: begin
        u = in_x;
        v = in_y;
      end
    endcase
    ue      = {u[W-1], u};
    ve      = {v[W-1], v};
    s_flip  = in_ctl_i.neg_s ^ (in_ctl_i.axis == AXIS_Y);
    sin_neg = -in_sin_i;
    c_d     = in_ctl_i.neg_c ? -in_cos_i : in_cos_i;
    sp_d    = s_flip ? sin_neg : in_sin_i;
    sn_d    = s_flip ? in_sin_i : sin_neg;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && r0) begin
      side0_q <= in_side_i;
      axis0_q <= in_ctl_i.axis;
      uh_q    <= ue[W:16];
      vh_q    <= ve[W:16];
      ul_q    <= u[15:0];
      vl_q    <= v[15:0];
      c_q     <= c_d;
      sp_q    <= sp_d;
      sn_q    <= sn_d;
    end
  end

  // partial products, coordinate split at bit 16
  logic signed [HP_W-1:0] uc_h_q, vs_h_q, us_h_q, vc_h_q;
  logic signed [LP_W-1:0] uc_l_q, vs_l_q, us_l_q, vc_l_q;
  logic signed [16:0]     ul_s, vl_s;

  assign ul_s = $signed({1'b0, ul_q});
  assign vl_s = $signed({1'b0, vl_q});

  always_ff @(posedge clk_i) begin
    if (v0_q && r1) begin
      side1_q <= side0_q;
      axis1_q <= axis0_q;
      uc_h_q  <= uh_q * c_q;
      vs_h_q  <= vh_q * sp_q;
      us_h_q  <= uh_q * sn_q;
      vc_h_q  <= vh_q * c_q;
      uc_l_q  <= ul_s * c_q;
      vs_l_q  <= vl_s * sp_q;
      us_l_q  <= ul_s * sn_q;
      vc_l_q  <= vl_s * c_q;
    end
  end

  logic signed [HS_W-1:0] hi1_q, hi2_q;
  logic signed [LS_W-1:0] lo1_q, lo2_q;

  always_ff @(posedge clk_i) begin
    if (v1_q && r2) begin
      side2_q <= side1_q;
      axis2_q <= axis1_q;
      hi1_q   <= HS_W'(uc_h_q) + HS_W'(vs_h_q);
      hi2_q   <= HS_W'(us_h_q) + HS_W'(vc_h_q);
      lo1_q   <= LS_W'(uc_l_q) + LS_W'(vs_l_q);
      lo2_q   <= LS_W'(us_l_q) + LS_W'(vc_l_q);
    end
  end

  logic signed [TOT_W-1:0] tot1, tot2;
  logic signed [W-1:0]     first, second;
  logic [W-1:0]            x_d, y_d, z_d, x_q, y_q, z_q;
  logic                    bad_d, bad_q;

  always_comb begin
    tot1   = (TOT_W'(hi1_q) <<< 16) + TOT_W'(lo1_q) + RND;
    tot2   = (TOT_W'(hi2_q) <<< 16) + TOT_W'(lo2_q) + RND;
    first  = round_sat(tot1);
    second = round_sat(tot2);
    bad_d  = 1'b0;
    case (axis2_q)
      AXIS_X: begin
        x_d = side2_q[W-1:0];
        y_d = first;
        z_d = second;
      end
      AXIS_Y: begin
        x_d = first;
        y_d = side2_q[2*W-1:W];
        z_d = second;
      end
      AXIS_Z: begin
        x_d = first;
        y_d = second;
        z_d = side2_q[3*W-1:2*W];
      end
      default: begin
        x_d   = '0;
        y_d   = '0;
        z_d   = '0;
        bad_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && r3) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      bad_q <= bad_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_x_o     = x_q;
  assign out_y_o     = y_q;
  assign out_z_o     = z_q;
  assign out_bad_o   = bad_q;

endmodule

/* rtl/axis_rotation_3d.sv */
// Pipeline: 8 angle reduction cells, fold, radian scaling, one cell per
// CORDIC stage, 4 MAC stages. Throughput: one request per cycle unless the
// output stalls; every stage is a register with its own valid and a ready
// that looks one stage ahead, so bubbles close up on a stall.
// Reset: rst_ni asynchronous active low clears all valid flags; data is not reset.
module axis_rotation_3d #(
  parameter int COORD_WIDTH   = rot3d_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = rot3d_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          s_axis_tvalid_i,
  output logic                                          s_axis_tready_o,
  // in_x, in_y, in_z, angle_degrees
  input  logic [((3*COORD_WIDTH+rot3d_pkg::ANGLE_W+7)/8)*8-1:0] s_axis_tdata_i,
  // axis_select
  input  logic [1:0]                                    s_axis_tuser_i,
  output logic                                          m_axis_tvalid_o,
  input  logic                                          m_axis_tready_i,
  // out_x, out_y, out_z
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]            m_axis_tdata_o,
  // bad_axis
  output logic [0:0]                                    m_axis_tuser_o
);
  import rot3d_pkg::*;

  localparam int W       = COORD_WIDTH;
  localparam int SIDE_W  = 3 * W;
  localparam int OUT_TD_W = ((3*W+7)/8)*8;
  localparam int N       = CORDIC_STAGES;

  localparam logic [ANG_RED_W-1:0] OFFS_R  = ANG_WRAP_OFFS[ANG_RED_W-1:0];
  localparam logic [ANG_RED_W-1:0] WRAP_R  = DEG360_Q16[ANG_RED_W-1:0] - OFFS_R;
  localparam logic [ANG_RED_W-1:0] D90_R   = DEG90_Q16[ANG_RED_W-1:0];
  localparam logic [ANG_RED_W-1:0] D180_R  = DEG180_Q16[ANG_RED_W-1:0];
  localparam logic [ANG_RED_W-1:0] D270_R  = DEG270_Q16[ANG_RED_W-1:0];
  localparam logic [ANG_RED_W-1:0] D360_R  = DEG360_Q16[ANG_RED_W-1:0];

  // angle reduction chain, angle offset by 2^31 to make it unsigned
  logic              mv   [RED_STEPS+1];
  logic              mrdy [RED_STEPS+1];
  logic [31:0]       mrem [RED_STEPS+1];
  rot3d_ctl_t        mctl [RED_STEPS+1];
  logic [SIDE_W-1:0] mside[RED_STEPS+1];
  logic [ANGLE_W-1:0] angle_in;

  assign angle_in = s_axis_tdata_i[SIDE_W+ANGLE_W-1:SIDE_W];

  always_comb begin
    mv[0]          = s_axis_tvalid_i;
    mrem[0]        = {~angle_in[ANGLE_W-1], angle_in[ANGLE_W-2:0]};
    mctl[0].axis   = rot3d_axis_e'(s_axis_tuser_i);
    mctl[0].neg_s  = 1'b0;
    mctl[0].neg_c  = 1'b0;
    mside[0]       = s_axis_tdata_i[SIDE_W-1:0];
  end

  assign s_axis_tready_o = mrdy[0];

  for (genvar g = 0; g < RED_STEPS; g++) begin : g_mod
    rot3d_mod_cell #(
      .SIDE_W (SIDE_W),
      .SHIFT  (RED_STEPS - 1 - g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (mv[g]),
      .in_ready_o  (mrdy[g]),
      .in_rem_i    (mrem[g]),
      .in_ctl_i    (mctl[g]),
      .in_side_i   (mside[g]),
      .out_valid_o (mv[g+1]),
      .out_ready_i (mrdy[g+1]),
      .out_rem_o   (mrem[g+1]),
      .out_ctl_o   (mctl[g+1]),
      .out_side_o  (mside[g+1])
    );
  end

  // fold to the first quadrant
  logic                 fold_v_q, fold_rdy;
  logic [ANG_RED_W-1:0] r_red, a_red, t_full;
  logic [T_W-1:0]       fold_t_q;
  rot3d_ctl_t           fold_ctl_d, fold_ctl_q;
  logic [SIDE_W-1:0]    fold_side_q;

  logic                       rad_v_q, rad_rdy;
  logic [49:0]                rad_prod;
  logic signed [CORDIC_W-1:0] rad_z_q;
  rot3d_ctl_t                 rad_ctl_q;
  logic [SIDE_W-1:0]          rad_side_q;

  logic                       cv   [N+1];
  logic                       crdy [N+1];
  logic signed [CORDIC_W-1:0] cx   [N+1];
  logic signed [CORDIC_W-1:0] cy   [N+1];
  logic signed [CORDIC_W-1:0] cz   [N+1];
  rot3d_ctl_t                 cctl [N+1];
  logic [SIDE_W-1:0]          cside[N+1];

  assign fold_rdy        = !fold_v_q || rad_rdy;
  assign mrdy[RED_STEPS] = fold_rdy;

  always_comb begin
    r_red      = mrem[RED_STEPS][ANG_RED_W-1:0];
    fold_ctl_d = mctl[RED_STEPS];
    if (r_red >= OFFS_R) begin
      a_red = r_red - OFFS_R;
    end else begin
      a_red = r_red + WRAP_R;
    end
    if (a_red < D90_R) begin
      t_full           = a_red;
      fold_ctl_d.neg_s = 1'b0;
      fold_ctl_d.neg_c = 1'b0;
    end else if (a_red < D180_R) begin
      t_full           = D180_R - a_red;
      fold_ctl_d.neg_s = 1'b0;
      fold_ctl_d.neg_c = 1'b1;
    end else if (a_red < D270_R) begin
      t_full           = a_red - D180_R;
      fold_ctl_d.neg_s = 1'b1;
      fold_ctl_d.neg_c = 1'b1;
    end else begin
      t_full           = D360_R - a_red;
      fold_ctl_d.neg_s = 1'b1;
      fold_ctl_d.neg_c = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_v_q <= 1'b0;
    end else if (fold_rdy) begin
      fold_v_q <= mv[RED_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv[RED_STEPS] && fold_rdy) begin
      fold_t_q    <= t_full[T_W-1:0];
      fold_ctl_q  <= fold_ctl_d;
      fold_side_q <= mside[RED_STEPS];
    end
  end

  // degrees to radians, Q30
  assign rad_rdy  = !rad_v_q || crdy[0];
  assign rad_prod = 50'(fold_t_q) * 50'(DEG2RAD_Q32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_v_q <= 1'b0;
    end else if (rad_rdy) begin
      rad_v_q <= fold_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold_v_q && rad_rdy) begin
      rad_z_q    <= $signed(rad_prod[49:18]);
      rad_ctl_q  <= fold_ctl_q;
      rad_side_q <= fold_side_q;
    end
  end

  // CORDIC chain
  assign cv[0]    = rad_v_q;
  assign cx[0]    = CORDIC_GAIN_Q30;
  assign cy[0]    = '0;
  assign cz[0]    = rad_z_q;
  assign cctl[0]  = rad_ctl_q;
  assign cside[0] = rad_side_q;

  for (genvar g = 0; g < N; g++) begin : g_cordic
    rot3d_cordic_cell #(
      .SIDE_W (SIDE_W),
      .STAGE  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cv[g]),
      .in_ready_o  (crdy[g]),
      .in_x_i      (cx[g]),
      .in_y_i      (cy[g]),
      .in_z_i      (cz[g]),
      .in_ctl_i    (cctl[g]),
      .in_side_i   (cside[g]),
      .out_valid_o (cv[g+1]),
      .out_ready_i (crdy[g+1]),
      .out_x_o     (cx[g+1]),
      .out_y_o     (cy[g+1]),
      .out_z_o     (cz[g+1]),
      .out_ctl_o   (cctl[g+1]),
      .out_side_o  (cside[g+1])
    );
  end

  logic [W-1:0] out_x, out_y, out_z;
  logic         out_bad;

  rot3d_mac #(
    .COORD_WIDTH (W)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cv[N]),
    .in_ready_o  (crdy[N]),
    .in_cos_i    (cx[N]),
    .in_sin_i    (cy[N]),
    .in_ctl_i    (cctl[N]),
    .in_side_i   (cside[N]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_z_o     (out_z),
    .out_bad_o   (out_bad)
  );

  assign m_axis_tdata_o = OUT_TD_W'({out_z, out_y, out_x});
  assign m_axis_tuser_o = out_bad;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("bad axis result carries non-zero coordinates");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while output stage empty");

  a_red_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv[RED_STEPS] |-> (mrem[RED_STEPS] < DEG360_Q16))
    else $error("angle reduction left remainder of 360 degrees or more");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_v_q |-> ({9'd0, fold_t_q} <= DEG90_Q16))
    else $error("folded angle above 90 degrees");

endmodule
